// ----- hdl/sorted_priority_list_assert.svh -----
// Assertion macros used by the sorted priority list RTL.
// Depends on nothing; included by spl_ctrl, which carries concurrent checks.
`ifndef SORTED_PRIORITY_LIST_ASSERT_SVH
`define SORTED_PRIORITY_LIST_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SPL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/spl_pkg.sv -----
// Types and constants for the sorted priority list.
// No dependencies; imported by spl_ctrl and sorted_priority_list.
`default_nettype none

package spl_pkg;

   localparam int FUNC_W   = 2;
   localparam int ID_W     = 16;
   localparam int PRI_W    = 8;
   localparam int STATUS_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT   = 2'd0,
      FUNC_POP_HIGH = 2'd1,
      FUNC_POP_LOW  = 2'd2,
      FUNC_POP_ID   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // One stored entry
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [PRI_W-1:0] pri;
   } entry_type;

   // One result beat
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [PRI_W-1:0] pri;
      status_type       status;
   } res_type;

endpackage

`default_nettype wire

// ----- hdl/sorted_priority_list.sv -----
// Sorted priority list: holds up to CAPACITY (id, priority) entries in descending
// priority, equal priorities in arrival order. Each request beat is an insert, a
// remove-highest, a remove-lowest or a remove-by-id, and returns exactly one
// response beat. One request is worked at a time; the entries live in a single
// RAM that the sequencer walks one slot per cycle. An insert into a non-empty
// store visits slots from the tail toward the head; remove-highest and
// remove-by-id always walk the whole list; an insert into an empty store writes
// slot 0 with no search and remove-lowest reads only the tail slot; a refused
// insert or a removal from an empty store goes straight to the response. The
// next request is accepted once the current response has gone to the response
// register. The response register lets the next request start while an earlier
// response waits. No clearing pass is needed.
// Depends on spl_pkg and spl_ctrl.
`default_nettype none

module sorted_priority_list #(
   parameter int CAPACITY = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [spl_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [spl_pkg::ID_W-1:0]      req_item_id,
   input  wire logic [spl_pkg::PRI_W-1:0]     req_item_priority,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [spl_pkg::ID_W-1:0]      rsp_out_id,
   output logic      [spl_pkg::PRI_W-1:0]     rsp_out_priority,
   output logic      [spl_pkg::STATUS_W-1:0]  rsp_status
);

   import spl_pkg::*;

   logic                 res_valid;
   res_type              res;
   logic                 res_take;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_out_id_ff, rsp_out_id_in;
   logic [PRI_W-1:0]     rsp_out_priority_ff, rsp_out_priority_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   spl_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_item_id       (req_item_id),
      .req_item_priority (req_item_priority),
      .res_valid         (res_valid),
      .res               (res),
      .res_take          (res_take)
   );

   // Load the response register when it is empty or its beat leaves
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in        = rsp_valid_ff;
      rsp_out_id_in       = rsp_out_id_ff;
      rsp_out_priority_in = rsp_out_priority_ff;
      rsp_status_in       = rsp_status_ff;
      if (res_take) begin
         rsp_valid_in        = 1'b1;
         rsp_out_id_in       = res.id;
         rsp_out_priority_in = res.pri;
         rsp_status_in       = res.status;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_out_id_ff       <= rsp_out_id_in;
      rsp_out_priority_ff <= rsp_out_priority_in;
      rsp_status_ff       <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_id       = rsp_out_id_ff;
   assign rsp_out_priority = rsp_out_priority_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

// ----- hdl/spl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module spl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read, read data lands in the next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/spl_ctrl.sv -----
// Sequencer for the sorted priority list: walks the entry RAM one slot a cycle,
// shifting entries while it searches. Depends on spl_pkg, spl_ram and the assert macros.
`default_nettype none
`include "sorted_priority_list_assert.svh"

module spl_ctrl #(
   parameter int CAPACITY = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [spl_pkg::FUNC_W-1:0]  req_func,
   input  wire logic [spl_pkg::ID_W-1:0]    req_item_id,
   input  wire logic [spl_pkg::PRI_W-1:0]   req_item_priority,
   output logic                             res_valid,
   output spl_pkg::res_type                 res,
   input  wire logic                        res_take
);

   import spl_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS,
      ST_PUT,
      ST_REM,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    cur_ff, cur_in;
   logic [AW-1:0]    put_pos_ff, put_pos_in;
   func_type         func_ff, func_in;
   entry_type        key_ff, key_in;
   logic             found_ff, found_in;
   res_type          res_ff, res_in;

   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   entry_type        ram_wr_data;
   logic [AW-1:0]    ram_rd_addr;
   entry_type        ram_rd_data;

   logic             accept;
   logic [CW-1:0]    cnt_dec;
   logic [AW-1:0]    last_idx;
   logic             cur_last;
   logic             hit;

   spl_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign cnt_dec   = count_ff - CW'(1);
   assign last_idx  = cnt_dec[AW-1:0];
   assign cur_last  = (CW'(cur_ff) == cnt_dec);
   assign hit       = !found_ff &&
                      ((func_ff != FUNC_POP_ID) || (ram_rd_data.id == key_ff.id));
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   // Next-state and RAM port logic
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      put_pos_in  = put_pos_ff;
      func_in     = func_ff;
      key_in      = key_ff;
      found_in    = found_ff;
      res_in      = res_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_ff + 1'b1;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = cur_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in       = func_type'(req_func);
               key_in.id     = req_item_id;
               key_in.pri    = req_item_priority;
               found_in      = 1'b0;
               res_in.id     = '0;
               res_in.pri    = '0;
               res_in.status = STATUS_OK;
               if (func_type'(req_func) == FUNC_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     res_in.status = STATUS_FULL;
                     state_in      = ST_DONE;
                  end else if (count_ff == '0) begin
                     put_pos_in = '0;
                     state_in   = ST_PUT;
                  end else begin
                     // scan from the tail toward the head
                     ram_rd_addr = last_idx;
                     cur_in      = last_idx;
                     state_in    = ST_INS;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in.status = STATUS_MISS;
                     state_in      = ST_DONE;
                  end else if (func_type'(req_func) == FUNC_POP_LOW) begin
                     ram_rd_addr = last_idx;
                     cur_in      = last_idx;
                     state_in    = ST_REM;
                  end else begin
                     ram_rd_addr = '0;
                     cur_in      = '0;
                     state_in    = ST_REM;
                  end
               end
            end
         end

         ST_INS: begin
            // stop behind the first entry of greater or equal priority
            if (ram_rd_data.pri >= key_ff.pri) begin
               put_pos_in = cur_ff + 1'b1;
               state_in   = ST_PUT;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cur_ff + 1'b1;
               ram_wr_data = ram_rd_data;
               if (cur_ff == '0) begin
                  put_pos_in = '0;
                  state_in   = ST_PUT;
               end else begin
                  cur_in      = cur_ff - 1'b1;
                  ram_rd_addr = cur_ff - 1'b1;
               end
            end
         end

         ST_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = put_pos_ff;
            ram_wr_data = key_ff;
            count_in    = count_ff + CW'(1);
            state_in    = ST_DONE;
         end

         ST_REM: begin
            // capture the first match, then pull later entries down one slot
            if (hit) begin
               res_in.id  = ram_rd_data.id;
               res_in.pri = ram_rd_data.pri;
            end
            if (found_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cur_ff - 1'b1;
               ram_wr_data = ram_rd_data;
            end
            found_in = found_ff || hit;
            if (cur_last) begin
               if (found_ff || hit) begin
                  count_in = cnt_dec;
               end else begin
                  res_in.status = STATUS_MISS;
               end
               state_in = ST_DONE;
            end else begin
               cur_in      = cur_ff + 1'b1;
               ram_rd_addr = cur_ff + 1'b1;
            end
         end

         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, count and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      cur_ff     <= cur_in;
      put_pos_ff <= put_pos_in;
      func_ff    <= func_in;
      key_ff     <= key_in;
      found_ff   <= found_in;
      res_ff     <= res_in;
   end

   `SPL_ASSERT_NEXT(a_full_insert_keeps_count, clock, reset, accept && (func_type'(req_func) == FUNC_INSERT) && (count_ff == CW'(CAPACITY)), $stable(count_ff), "full insert changed the entry count")

   `SPL_ASSERT_NOW(a_write_in_range, clock, reset, ram_wr_en, CW'(ram_wr_addr) < CW'(CAPACITY), "RAM write beyond capacity")

   `SPL_ASSERT_NOW(a_rem_write_after_match, clock, reset, (state_ff == ST_REM) && ram_wr_en, found_ff, "shift during removal before a match")

   `SPL_ASSERT_NEXT(a_handoff_to_idle, clock, reset, res_valid && res_take, state_ff == ST_IDLE, "sequencer did not return to idle after handoff")

endmodule

`default_nettype wire
